[hdl/csip_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Call signature index parser package
// Shared types and constants for the signature parser and its step logic.
// ----------------------------------------------------------------------------
package csip_pkg;

	localparam int IDX_W         = 29;
	localparam int MAX_CODES_DEF = 10;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	localparam logic [IDX_W-1:0] ACC_INIT = IDX_W'(1);

	typedef enum logic [1:0] {
		PH_OPEN,
		PH_ELEMS,
		PH_RET,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		SK_NONE,
		SK_NEXT,
		SK_XFIRST,
		SK_XDIG,
		SK_XNAME,
		SK_AFIRST,
		SK_ADIG
	} skip_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD,
		ST_MANY
	} status_t;

	typedef struct packed {
		phase_t            phase;
		skip_t             skip;
		logic [IDX_W-1:0]  acc;
		status_t           err;
	} parse_state_t;

endpackage
`default_nettype wire

[hdl/call_signature_index_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Call signature index parser
// Parses a type signature one character per transaction and returns the
// base-6 call index and a status when the zero terminator arrives.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------
//  input   | sig_valid / sig_ready  | sig_char
//  result  | res_valid / res_ready  | call_index, status
//
// One character is taken per cycle unless a terminator is stalled in the
// input register. A character is captured in the input register when it is
// accepted, and the step logic then folds it into the parse state; the result
// register is loaded as the terminator leaves the input register.
// Only the terminator produces a result; it stalls in the input register
// while the result register is still full and not being taken.
// Reset puts the parser in its start state, with no result pending.
module call_signature_index_parser #(
	parameter int MAX_CODES = csip_pkg::MAX_CODES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       sig_valid,
	output logic                            sig_ready,
	input  wire logic [7:0]                 sig_char,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output logic [csip_pkg::IDX_W-1:0]      call_index,
	output logic [1:0]                      status
);

	localparam int COUNT_W = $clog2(MAX_CODES + 1);

	localparam csip_pkg::parse_state_t STATE_INIT = '{
		phase: csip_pkg::PH_OPEN,
		skip:  csip_pkg::SK_NONE,
		acc:   csip_pkg::ACC_INIT,
		err:   csip_pkg::ST_OK
	};

	logic                       valid_s1;
	logic [7:0]                 char_s1;
	csip_pkg::parse_state_t     state_q;
	logic [COUNT_W-1:0]         count_q;
	csip_pkg::parse_state_t     state_nxt;
	logic [COUNT_W-1:0]         count_nxt;
	logic                       is_term;
	logic                       advance;
	logic                       res_valid_q;
	logic [csip_pkg::IDX_W-1:0] call_index_q;
	logic [1:0]                 status_q;

	csip_step #(
		.MAX_CODES (MAX_CODES),
		.COUNT_W   (COUNT_W)
	) u_step (
		.c         (char_s1),
		.cur       (state_q),
		.cur_count (count_q),
		.nxt       (state_nxt),
		.nxt_count (count_nxt)
	);

	assign is_term   = (char_s1 == csip_pkg::CH_NUL);
	// A terminator needs room in the result register; other characters never wait.
	assign advance   = valid_s1 && (!is_term || !res_valid_q || res_ready);
	assign sig_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sig_ready) begin
			valid_s1 <= sig_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sig_ready && sig_valid) begin
			char_s1 <= sig_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_INIT;
			count_q <= '0;
		end else if (advance) begin
			if (is_term) begin
				state_q <= STATE_INIT;
				count_q <= '0;
			end else begin
				state_q <= state_nxt;
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_term) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_term) begin
			call_index_q <= (state_nxt.err == csip_pkg::ST_OK) ? state_nxt.acc : '0;
			status_q     <= state_nxt.err;
		end
	end

	assign res_valid  = res_valid_q;
	assign call_index = call_index_q;
	assign status     = status_q;

endmodule
`default_nettype wire

[hdl/csip_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Signature parser step logic
// Next parse state for one character: classification, extent skipping and
// the base-6 index update.
// ----------------------------------------------------------------------------
module csip_step #(
	parameter int MAX_CODES = csip_pkg::MAX_CODES_DEF,
	parameter int COUNT_W   = $clog2(MAX_CODES + 1)
) (
	input  wire logic [7:0]             c,
	input  wire csip_pkg::parse_state_t cur,
	input  wire logic [COUNT_W-1:0]     cur_count,
	output csip_pkg::parse_state_t      nxt,
	output logic [COUNT_W-1:0]          nxt_count
);

	typedef struct packed {
		logic       ok;
		logic [2:0] code;
	} code_res_t;

	function automatic code_res_t base_code(input logic [7:0] ch);
		code_res_t r;
		r.ok = 1'b1;
		unique case (ch)
			"a", "b", "c", "h", "i", "j", "k", "s", "t", "v", "w": r.code = 3'd0;
			"l", "m", "x", "y":                                   r.code = 3'd1;
			"f":                                                  r.code = 3'd2;
			"d", "e":                                             r.code = 3'd3;
			"g", "n", "o", "p", "q", "r", "C", "Q", "X", "L":     r.code = 3'd4;
			"P":                                                  r.code = 3'd5;
			default: begin
				r.ok   = 1'b0;
				r.code = 3'd0;
			end
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= "0") && (ch <= "9");
	endfunction

	function automatic logic is_lower(input logic [7:0] ch);
		return (ch >= "a") && (ch <= "z");
	endfunction

	code_res_t                  bc;
	logic                       push_ok;
	csip_pkg::status_t          push_err;
	csip_pkg::skip_t            post_push;
	csip_pkg::skip_t            mode;
	logic                       to_none;
	logic [csip_pkg::IDX_W-1:0] acc6;

	always_comb begin
		bc       = base_code(c);
		push_ok  = bc.ok && (cur_count < COUNT_W'(MAX_CODES));
		push_err = bc.ok ? csip_pkg::ST_MANY : csip_pkg::ST_BAD;
		acc6     = (cur.acc << 2) + (cur.acc << 1) + csip_pkg::IDX_W'(bc.code);

		// The code character itself is then treated as the element's first
		// skip character: lowercase ends the element, X and L open a name.
		if (is_lower(c)) begin
			post_push = csip_pkg::SK_NONE;
		end else if (c == "X" || c == "L") begin
			post_push = csip_pkg::SK_XFIRST;
		end else begin
			post_push = csip_pkg::SK_NEXT;
		end

		nxt       = cur;
		nxt_count = cur_count;
		to_none   = 1'b0;

		// A non-digit after an array length is handled as a prefix character.
		mode = cur.skip;
		if (mode == csip_pkg::SK_ADIG && !is_digit(c)) begin
			mode = csip_pkg::SK_NEXT;
		end

		unique case (cur.phase)
			csip_pkg::PH_OPEN: begin
				if (c == csip_pkg::CH_OPEN) begin
					nxt.phase = csip_pkg::PH_ELEMS;
				end else begin
					nxt.phase = csip_pkg::PH_DONE;
					nxt.skip  = csip_pkg::SK_NONE;
					nxt.err   = csip_pkg::ST_BAD;
				end
			end
			csip_pkg::PH_ELEMS: begin
				unique case (mode)
					csip_pkg::SK_NONE: to_none = 1'b1;
					csip_pkg::SK_NEXT: begin
						if (is_lower(c)) begin
							nxt.skip = csip_pkg::SK_NONE;
						end else if (c == "C" || c == "D" || c == "R" || c == "P" || c == "Q") begin
							nxt.skip = csip_pkg::SK_NEXT;
						end else if (c == "X" || c == "L" || c == "U") begin
							nxt.skip = csip_pkg::SK_XFIRST;
						end else if (c == "A") begin
							nxt.skip = csip_pkg::SK_AFIRST;
						end else begin
							to_none = 1'b1;
						end
					end
					csip_pkg::SK_XFIRST: begin
						if (is_digit(c)) begin
							nxt.skip = csip_pkg::SK_XDIG;
						end else if (c == csip_pkg::CH_SEMI) begin
							nxt.skip = csip_pkg::SK_NONE;
						end else if (c == csip_pkg::CH_NUL) begin
							to_none = 1'b1;
						end else begin
							nxt.skip = csip_pkg::SK_XNAME;
						end
					end
					csip_pkg::SK_XDIG: begin
						if (is_digit(c)) begin
							nxt.skip = csip_pkg::SK_XDIG;
						end else begin
							to_none = 1'b1;
						end
					end
					csip_pkg::SK_XNAME: begin
						if (c == csip_pkg::CH_SEMI) begin
							nxt.skip = csip_pkg::SK_NONE;
						end else if (c == csip_pkg::CH_NUL) begin
							to_none = 1'b1;
						end else begin
							nxt.skip = csip_pkg::SK_XNAME;
						end
					end
					csip_pkg::SK_AFIRST: begin
						if (is_digit(c)) begin
							nxt.skip = csip_pkg::SK_ADIG;
						end else if (c == csip_pkg::CH_NUL) begin
							to_none = 1'b1;
						end else begin
							nxt.skip = csip_pkg::SK_NEXT;
						end
					end
					csip_pkg::SK_ADIG: nxt.skip = csip_pkg::SK_ADIG;
					default:           to_none = 1'b1;
				endcase

				// The character was not part of the current element, so it
				// starts at an element boundary.
				if (to_none) begin
					nxt.skip = csip_pkg::SK_NONE;
					if (c == csip_pkg::CH_NUL) begin
						nxt.phase = csip_pkg::PH_DONE;
					end else if (c == csip_pkg::CH_CLOSE) begin
						nxt.phase = csip_pkg::PH_RET;
					end else if (push_ok) begin
						nxt.acc   = acc6;
						nxt_count = cur_count + COUNT_W'(1);
						nxt.skip  = post_push;
					end else begin
						nxt.phase = csip_pkg::PH_DONE;
						nxt.err   = push_err;
					end
				end
			end
			csip_pkg::PH_RET: begin
				nxt.phase = csip_pkg::PH_DONE;
				nxt.skip  = csip_pkg::SK_NONE;
				if (push_ok) begin
					nxt.acc   = acc6;
					nxt_count = cur_count + COUNT_W'(1);
				end else begin
					nxt.err = push_err;
				end
			end
			csip_pkg::PH_DONE: nxt.phase = csip_pkg::PH_DONE;
			default:           nxt.phase = csip_pkg::PH_DONE;
		endcase
	end

endmodule
`default_nettype wire
